// ===== hdl/rcmr_pkg.sv =====
// Shared widths, item types and cell control for the rod cutting revenue block.
`default_nettype none

package rcmr_pkg;

    localparam int REV_BITS       = 22;
    localparam int PRICE_W        = 16;
    localparam int MAX_LEN_DEF    = 64;
    localparam int PRICE_BITS_DEF = 16;

    typedef struct packed {
        logic [PRICE_W-1:0] price;
        logic               last;
    } t_in_item;

    typedef struct packed {
        logic [REV_BITS-1:0] best_revenue;
        logic                overflow;
    } t_out_item;

    // broadcast to every cell of the chain
    typedef struct packed {
        logic load;    // a price item is being stored
        logic init;    // first item of a job: first cell takes best of zero length
        logic shift;   // new best value enters the chain
    } t_cell_ctl;

endpackage

`default_nettype wire

// ===== hdl/rcmr_stream_if.sv =====
// Valid/ready stream interface carrying one item per handshake.
`default_nettype none

interface rcmr_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hdl/rcmr_cell.sv =====
// One cell of the revenue chain: holds one price and one best-table entry.
`default_nettype none

module rcmr_cell
    import rcmr_pkg::*;
#(
    parameter int IDX = 1,
    parameter int CW  = 7,
    parameter int PW  = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cell_ctl           i_ctl,
    input  logic [CW-1:0]       i_count,
    input  logic [PW-1:0]       i_price,
    input  logic                i_tok,
    input  logic [REV_BITS-1:0] i_acc,
    input  logic [REV_BITS-1:0] i_best,
    output logic                o_tok,
    output logic [REV_BITS-1:0] o_acc,
    output logic [REV_BITS-1:0] o_best
);

    logic [PW-1:0]       r_price;
    logic [REV_BITS-1:0] r_best;
    logic [REV_BITS-1:0] r_acc;
    logic                r_tok;
    logic [REV_BITS:0]   w_sum;
    logic [REV_BITS-1:0] w_cand;
    logic                w_active;

    // r_best holds best[k - IDX] while best[k] is being swept
    assign w_active = (i_count >= CW'(IDX));
    assign w_sum    = {1'b0, r_best} + (REV_BITS+1)'(r_price);
    assign w_cand   = w_sum[REV_BITS] ? {REV_BITS{1'b1}} : w_sum[REV_BITS-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= 1'b0;
        end else begin
            r_tok <= i_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load && (i_count == CW'(IDX - 1))) begin
            r_price <= i_price;
        end
        if (i_ctl.init && (IDX == 1)) begin
            r_best <= '0;
        end else if (i_ctl.shift) begin
            r_best <= i_best;
        end
        if (i_tok) begin
            r_acc <= (w_active && (w_cand > i_acc)) ? w_cand : i_acc;
        end
    end

    assign o_tok  = r_tok;
    assign o_acc  = r_acc;
    assign o_best = r_best;

endmodule

`default_nettype wire

// ===== hdl/rod_cutting_max_revenue.sv =====
// Rod cutting best revenue: each stored price runs one max-sweep down a chain of MAX_LEN cells.
// A result is registered when its last item's sweep token, passing one cell a cycle, leaves the
// chain end, or when a dropped last item is accepted; a busy output holds it in the wait state.
// New items are taken only while idle, not during a sweep; items beyond MAX_LEN are not stored.
// Reset: synchronous, active low; clears the item count, drop flag, sweep token and output valid.
`default_nettype none

module rod_cutting_max_revenue
    import rcmr_pkg::*;
#(
    parameter int MAX_LEN    = MAX_LEN_DEF,
    parameter int PRICE_BITS = PRICE_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    rcmr_stream_if.sink   i_in,
    rcmr_stream_if.source o_out
);

    localparam int CW = $clog2(MAX_LEN + 1);
    localparam int PW = (PRICE_BITS < PRICE_W) ? PRICE_BITS : PRICE_W;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SWEEP = 2'd1;
    localparam logic [1:0] S_WAIT  = 2'd2;

    logic [1:0]          r_state;
    logic [CW-1:0]       r_count;
    logic                r_drop;
    logic                r_last_pend;
    logic                r_start;
    logic                r_ov;
    logic [REV_BITS-1:0] r_obest;
    logic                r_oovf;
    logic [REV_BITS-1:0] r_pbest;
    logic                r_povf;
    logic [REV_BITS-1:0] r_best_k;

    logic                w_accept;
    logic                w_store;
    logic                w_done;
    logic                w_out_free;
    logic                w_emit;
    logic [REV_BITS-1:0] w_emit_best;
    logic                w_emit_ovf;
    t_cell_ctl           w_ctl;
    logic [PW-1:0]       w_price;

    logic [MAX_LEN:0]    w_tok;
    logic [REV_BITS-1:0] w_acc  [0:MAX_LEN];
    logic [REV_BITS-1:0] w_best [0:MAX_LEN-1];

    assign i_in.ready = (r_state == S_IDLE);
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_store    = w_accept && (r_count < CW'(MAX_LEN));
    assign w_done     = w_tok[MAX_LEN];
    assign w_out_free = !r_ov || o_out.ready;
    assign w_price    = i_in.data.price[PW-1:0];

    assign w_ctl.load  = w_store;
    assign w_ctl.init  = w_store && (r_count == '0);
    assign w_ctl.shift = w_done;

    always_comb begin
        w_emit      = 1'b0;
        w_emit_best = r_best_k;
        w_emit_ovf  = 1'b1;
        priority if (w_accept && !w_store && i_in.data.last) begin
            w_emit = 1'b1;
        end else if ((r_state == S_SWEEP) && w_done && r_last_pend) begin
            w_emit      = 1'b1;
            w_emit_best = w_acc[MAX_LEN];
            w_emit_ovf  = r_drop;
        end else begin
            w_emit = 1'b0;
        end
    end

    assign w_tok[0] = r_start;
    assign w_acc[0] = '0;
    assign w_best[0] = w_acc[MAX_LEN];

    for (genvar g = 1; g <= MAX_LEN; g++) begin : g_cell
        if (g < MAX_LEN) begin : g_mid
            rcmr_cell #(.IDX(g), .CW(CW), .PW(PW)) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctl   (w_ctl),
                .i_count (r_count),
                .i_price (w_price),
                .i_tok   (w_tok[g-1]),
                .i_acc   (w_acc[g-1]),
                .i_best  (w_best[g-1]),
                .o_tok   (w_tok[g]),
                .o_acc   (w_acc[g]),
                .o_best  (w_best[g])
            );
        end else begin : g_end
            rcmr_cell #(.IDX(g), .CW(CW), .PW(PW)) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctl   (w_ctl),
                .i_count (r_count),
                .i_price (w_price),
                .i_tok   (w_tok[g-1]),
                .i_acc   (w_acc[g-1]),
                .i_best  (w_best[g-1]),
                .o_tok   (w_tok[g]),
                .o_acc   (w_acc[g]),
                .o_best  ()
            );
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_drop      <= 1'b0;
            r_last_pend <= 1'b0;
            r_start     <= 1'b0;
            r_ov        <= 1'b0;
        end else begin
            r_start <= w_store;
            if ((w_emit || (r_state == S_WAIT)) && w_out_free) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        priority if (w_store) begin
                            r_count     <= r_count + 1'b1;
                            r_last_pend <= i_in.data.last;
                            r_state     <= S_SWEEP;
                        end else if (i_in.data.last) begin
                            r_count <= '0;
                            r_drop  <= 1'b0;
                            if (!w_out_free) begin
                                r_state <= S_WAIT;
                            end
                        end else begin
                            r_drop <= 1'b1;
                        end
                    end
                end
                S_SWEEP: begin
                    if (w_done) begin
                        if (r_last_pend) begin
                            r_count <= '0;
                            r_drop  <= 1'b0;
                            r_state <= w_out_free ? S_IDLE : S_WAIT;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_WAIT: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_done) begin
            r_best_k <= w_acc[MAX_LEN];
        end
        if (w_emit) begin
            r_pbest <= w_emit_best;
            r_povf  <= w_emit_ovf;
        end
        if (w_emit && w_out_free) begin
            r_obest <= w_emit_best;
            r_oovf  <= w_emit_ovf;
        end else if ((r_state == S_WAIT) && w_out_free) begin
            r_obest <= r_pbest;
            r_oovf  <= r_povf;
        end
    end

    assign o_out.valid             = r_ov;
    assign o_out.data.best_revenue = r_obest;
    assign o_out.data.overflow     = r_oovf;

    a_done_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done |-> (r_state == S_SWEEP))
        else $error("sweep token reached chain end outside a sweep");

    a_one_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_tok))
        else $error("more than one sweep token in the chain");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_LEN))
        else $error("item count beyond chain length");

    a_drop_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && !w_store && !i_in.data.last) |=> r_drop)
        else $error("dropped item did not set the drop flag");

endmodule

`default_nettype wire
